>>> rtl/qrv_pkg.sv
// qrv_pkg: shared types and codes of the queue with remove-by-value
// used by qrv_cell, qrv_ctrl and queue_with_remove_by_value_top
package qrv_pkg;

	localparam int DATA_W        = 32;
	localparam int DEPTH_DEFAULT = 16;

	// operation codes of a request
	localparam logic [1:0] OP_DEQUEUE = 2'd0;
	localparam logic [1:0] OP_ENQUEUE = 2'd1;
	localparam logic [1:0] OP_REMOVE  = 2'd2;

	// status codes of a response
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]               op;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                     removed;
		logic signed [DATA_W-1:0] removed_value;
		logic [1:0]               status;
	} rsp_t;

	// per-cell command: load takes the write bus, shift takes the neighbor
	typedef struct packed {
		logic load;
		logic shift;
	} cell_cmd_t;

endpackage

>>> rtl/qrv_cell.sv
// qrv_cell: one storage cell of the queue chain
// depends on qrv_pkg
module qrv_cell (
	input  logic                              clk,
	input  qrv_pkg::cell_cmd_t                cmd,
	input  logic signed [qrv_pkg::DATA_W-1:0] wr_data,
	input  logic signed [qrv_pkg::DATA_W-1:0] nbr_data,
	output logic signed [qrv_pkg::DATA_W-1:0] data
);
	import qrv_pkg::*;

	logic signed [DATA_W-1:0] data_q;

	// load wins over shift: the tail write-back lands in the freed cell
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			data_q <= wr_data;
		end else if (cmd.shift) begin
			data_q <= nbr_data;
		end
	end

	assign data = data_q;

endmodule

>>> rtl/qrv_ctrl.sv
// qrv_ctrl: sequencer, fill count and response buffer of the queue
// depends on qrv_pkg; drives the qrv_cell chain
module qrv_ctrl #(
	parameter int DEPTH = qrv_pkg::DEPTH_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  qrv_pkg::req_t                     req,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output qrv_pkg::rsp_t                     rsp,
	input  logic signed [qrv_pkg::DATA_W-1:0] head,
	output qrv_pkg::cell_cmd_t                cmd [DEPTH],
	output logic signed [qrv_pkg::DATA_W-1:0] wr_data
);
	import qrv_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic {
		S_IDLE,
		S_ROTATE
	} state_t;

	state_t                   state_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            steps_q;
	logic signed [DATA_W-1:0] key_q;
	logic                     hit_q;
	logic signed [DATA_W-1:0] rval_q;
	rsp_t                     rsp_q;
	logic                     rsp_valid_q;
	rsp_t                     skid_q;
	logic                     skid_valid_q;

	logic          accept;
	logic          head_match;
	logic          shift_all;
	logic          wr_en;
	logic [CW-1:0] wr_idx;
	logic          res_fire;
	rsp_t          res;
	logic          start_rot;
	logic          rsp_take;

	assign req_stall  = (state_q != S_IDLE) | skid_valid_q;
	assign accept     = req_valid & ~req_stall;
	assign head_match = (head == key_q) & ~hit_q;
	assign rsp_take   = rsp_valid_q & ~rsp_stall;

	always_comb begin
		shift_all = 1'b0;
		wr_en     = 1'b0;
		wr_idx    = count_q;
		wr_data   = req.value;
		res_fire  = 1'b0;
		res       = '{removed: 1'b0, removed_value: '0, status: ST_DONE};
		start_rot = 1'b0;
		if (state_q == S_IDLE) begin
			if (accept) begin
				case (req.op)
					OP_DEQUEUE: begin
						res_fire = 1'b1;
						if (count_q == '0) begin
							res.status = ST_MISS;
						end else begin
							shift_all         = 1'b1;
							res.removed       = 1'b1;
							res.removed_value = head;
						end
					end
					OP_ENQUEUE: begin
						res_fire = 1'b1;
						if (count_q == CW'(DEPTH)) begin
							res.status = ST_FULL;
						end else begin
							wr_en = 1'b1;
						end
					end
					OP_REMOVE: begin
						if (count_q == '0) begin
							res_fire   = 1'b1;
							res.status = ST_MISS;
						end else begin
							start_rot = 1'b1;
						end
					end
					default: begin
						res_fire = 1'b1;
					end
				endcase
			end
		end else begin
			// pop the head, write it back at the tail unless it is the first match
			shift_all = 1'b1;
			wr_data   = head;
			wr_idx    = count_q - CW'(1);
			wr_en     = ~head_match;
			if (steps_q == CW'(1)) begin
				res_fire = 1'b1;
				if (hit_q | head_match) begin
					res.removed       = 1'b1;
					res.removed_value = hit_q ? rval_q : head;
				end else begin
					res.status = ST_MISS;
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cmd[i].load  = wr_en & (wr_idx == CW'(i));
			cmd[i].shift = shift_all;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			steps_q      <= '0;
			hit_q        <= 1'b0;
			rsp_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (wr_en) begin
							count_q <= count_q + CW'(1);
						end else if (shift_all) begin
							count_q <= count_q - CW'(1);
						end
					end
					if (start_rot) begin
						state_q <= S_ROTATE;
						steps_q <= count_q;
						key_q   <= req.value;
						hit_q   <= 1'b0;
					end
				end
				S_ROTATE: begin
					steps_q <= steps_q - CW'(1);
					if (head_match) begin
						hit_q   <= 1'b1;
						rval_q  <= head;
						count_q <= count_q - CW'(1);
					end
					if (steps_q == CW'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// two-slot response buffer
			if (rsp_take || !rsp_valid_q) begin
				rsp_valid_q <= skid_valid_q | res_fire;
				rsp_q       <= skid_valid_q ? skid_q : res;
				if (skid_valid_q && res_fire) begin
					skid_q <= res;
				end else begin
					skid_valid_q <= 1'b0;
				end
			end else if (res_fire) begin
				skid_q       <= res;
				skid_valid_q <= 1'b1;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> rtl/queue_with_remove_by_value_top.sv
// queue_with_remove_by_value_top: bounded fifo queue with delete-by-value
// depends on qrv_pkg, qrv_cell and qrv_ctrl
//
// usage
//   request channel (req_valid, req_stall, req): one operation per request,
//   dequeue head, enqueue at tail or remove the first entry equal to a value
//   response channel (rsp_valid, rsp_stall, rsp): exactly one response per
//   request, in request order: removed flag, removed value, status
//   a transfer happens on a clock edge with valid high and stall low
// request handling
//   enqueue, dequeue and unused op codes: response registered into the buffer
//   at the edge that takes the request, one request per cycle while req_stall is low
//   remove by value: the chain rotates once through all fill_count entries,
//   comparing the head each cycle; the response is registered as the rotation
//   ends (at once on empty), and no new request is taken while it rotates
// reset
//   arst_n clears the fill count, sequencer and response buffer; cell contents
//   are not reset and only entries below the fill count are ever read
// receiver stall
//   responses wait in a two-slot buffer; req_stall rises when its second slot
//   fills, so no response is ever dropped
module queue_with_remove_by_value_top #(
	parameter int DEPTH = qrv_pkg::DEPTH_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  qrv_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output qrv_pkg::rsp_t rsp
);
	import qrv_pkg::*;

	// cell i holds queue position i, cell 0 is the head
	logic signed [DATA_W-1:0] cell_data [DEPTH];
	cell_cmd_t                cmd [DEPTH];
	logic signed [DATA_W-1:0] wr_data;

	// sequencer: decodes requests, keeps the fill count, steers the chain
	qrv_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.head     (cell_data[0]),
		.cmd      (cmd),
		.wr_data  (wr_data)
	);

	// chain of cells: a shift moves every entry one place toward the head
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == DEPTH - 1) begin : g_last
			// last cell has no right neighbor; it holds its own value
			qrv_cell u_cell (
				.clk     (clk),
				.cmd     (cmd[i]),
				.wr_data (wr_data),
				.nbr_data(cell_data[i]),
				.data    (cell_data[i])
			);
		end else begin : g_mid
			qrv_cell u_cell (
				.clk     (clk),
				.cmd     (cmd[i]),
				.wr_data (wr_data),
				.nbr_data(cell_data[i+1]),
				.data    (cell_data[i])
			);
		end
	end

endmodule

>>> bench/tb_queue_with_remove_by_value_top.sv
// tb_queue_with_remove_by_value_top: self-checking bench for the bounded fifo with remove-by-value
// drives queue_with_remove_by_value_top with directed and random requests, predicts every response
// depends on qrv_pkg and the rtl under rtl/
module tb_queue_with_remove_by_value_top;
	import qrv_pkg::*;

	localparam int         QDEPTH       = DEPTH_DEFAULT;
	localparam int         RANDOM_REQS  = 830;
	localparam int         IDLE_LIMIT   = 2000;
	localparam int         TAIL_CYCLES  = 40;
	// op code 3 has no meaning, the block answers it with a plain done
	localparam logic [1:0] OP_UNUSED    = 2'd3;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic rsp_stall = 1'b0;
	req_t req       = '0;
	logic req_stall;
	logic rsp_valid;
	rsp_t rsp;

	// requests not yet presented, responses still owed by the block
	req_t pending_reqs[$];
	rsp_t owed_rsps[$];

	// image of the queue contents, head at index 0
	logic signed [DATA_W-1:0] queue_image[$];

	int errors      = 0;
	int n_checked   = 0;
	int n_removed   = 0;
	int n_miss      = 0;
	int n_full      = 0;
	int max_fill    = 0;
	int cyc         = 0;
	int drv_gap     = 0;
	int stall_left  = 0;

	queue_with_remove_by_value_top #(
		.DEPTH(QDEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// clock, period 8
	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	// applies one request to the queue image and returns the response it must produce
	function automatic rsp_t apply_queue_op(input req_t r);
		rsp_t o;
		int   hit;
		o = '0;
		o.status = ST_DONE;
		hit = -1;
		case (r.op)
			OP_DEQUEUE: begin
				if (queue_image.size() == 0) begin
					o.status = ST_MISS;
				end else begin
					o.removed       = 1'b1;
					o.removed_value = queue_image.pop_front();
				end
			end
			OP_ENQUEUE: begin
				if (queue_image.size() >= QDEPTH) begin
					o.status = ST_FULL;
				end else begin
					queue_image.push_back(r.value);
				end
			end
			OP_REMOVE: begin
				// first match counted from the head, head itself included
				for (int i = 0; i < queue_image.size(); i++) begin
					if (hit < 0 && queue_image[i] == r.value) begin
						hit = i;
					end
				end
				if (hit < 0) begin
					o.status = ST_MISS;
				end else begin
					o.removed       = 1'b1;
					o.removed_value = queue_image[hit];
					queue_image.delete(hit);
				end
			end
			default: ;
		endcase
		if (queue_image.size() > max_fill) begin
			max_fill = queue_image.size();
		end
		return o;
	endfunction

	// idle length: none in a quiet window, else mostly short, a few long
	function automatic int draw_gap(input bit quiet);
		int r;
		if (quiet) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic push_req(input logic [1:0] op, input logic [DATA_W-1:0] value);
		req_t r;
		r.op    = op;
		r.value = value;
		pending_reqs.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		$display("%0t: response %0d, %s: got %h want %h", $time, n_checked, what, got, want);
		errors++;
	endtask

	// driver: presents the next pending request, holds it while stalled
	always @(posedge clk) begin : drive
		bit taken;
		if (!arst_n) begin
			req_valid <= 1'b0;
			drv_gap   <= 0;
		end else begin
			taken = req_valid && !req_stall;
			if (taken) begin
				// predict in request order, at the edge that moves the request
				owed_rsps.push_back(apply_queue_op(req));
			end
			if (req_valid && !taken) begin
				// stalled: valid and payload stay as they are
			end else if (drv_gap != 0) begin
				req_valid <= 1'b0;
				drv_gap   <= drv_gap - 1;
			end else if (pending_reqs.size() != 0) begin
				req       <= pending_reqs.pop_front();
				req_valid <= 1'b1;
				// gap that follows this request once it is taken
				drv_gap   <= draw_gap((cyc % 512) < 96);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// monitor: checks every accepted response against the oldest owed one
	always @(posedge clk) begin : check
		rsp_t want;
		int   n;
		if (!arst_n) begin
			rsp_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (owed_rsps.size() == 0) begin
					report_mismatch("response with no request behind it",
						rsp.removed_value, '0);
				end else begin
					want = owed_rsps.pop_front();
					if (rsp.removed !== want.removed) begin
						report_mismatch("removed", DATA_W'(rsp.removed),
							DATA_W'(want.removed));
					end
					if (rsp.removed_value !== want.removed_value) begin
						report_mismatch("removed_value", rsp.removed_value,
							want.removed_value);
					end
					if (rsp.status !== want.status) begin
						report_mismatch("status", DATA_W'(rsp.status),
							DATA_W'(want.status));
					end
					if (want.removed) begin
						n_removed++;
					end
					if (want.status == ST_MISS) begin
						n_miss++;
					end
					if (want.status == ST_FULL) begin
						n_full++;
					end
				end
				n_checked++;
			end
			// receiver back-pressure; its quiet window drifts against the driver's
			if (stall_left != 0) begin
				rsp_stall  <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				n = draw_gap((cyc % 384) < 96);
				rsp_stall  <= (n != 0);
				stall_left <= (n != 0) ? n - 1 : 0;
			end
		end
	end

	// watchdog: too long without any transfer on either channel
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("timeout: %0d cycles without a transfer, %0d responses owed",
			IDLE_LIMIT, owed_rsps.size());
		$display("*** FAILED ***");
		$finish;
	end

	// stimulus and end of run
	initial begin : stimulus
		logic signed [DATA_W-1:0] pool[8];
		int                       bias;
		int                       enq_pct;
		int                       r;
		logic [1:0]               op;
		logic [DATA_W-1:0]        value;

		// directed: empty cases, unused op, value extremes, duplicates,
		// remove of head, middle and tail, not found, drain to empty
		push_req(OP_DEQUEUE, 32'h0000_0000);
		push_req(OP_REMOVE,  32'h0000_0005);
		push_req(OP_UNUSED,  32'hffff_ffff);
		push_req(OP_ENQUEUE, 32'h8000_0000);
		push_req(OP_ENQUEUE, 32'h7fff_ffff);
		push_req(OP_ENQUEUE, 32'h0000_0000);
		push_req(OP_ENQUEUE, 32'hffff_ffff);
		push_req(OP_ENQUEUE, 32'h7fff_ffff);
		push_req(OP_REMOVE,  32'h7fff_ffff);
		push_req(OP_REMOVE,  32'h8000_0000);
		push_req(OP_REMOVE,  32'h0001_2345);
		push_req(OP_UNUSED,  32'h0000_0000);
		push_req(OP_REMOVE,  32'h7fff_ffff);
		push_req(OP_DEQUEUE, 32'hffff_ffff);
		push_req(OP_DEQUEUE, 32'h5555_aaaa);
		push_req(OP_DEQUEUE, 32'haaaa_5555);
		push_req(OP_REMOVE,  32'h0000_0000);

		// small value pool so that removes hit and duplicates pile up
		pool[0] = 32'h8000_0000;
		pool[1] = 32'h7fff_ffff;
		pool[2] = 32'h0000_0000;
		pool[3] = 32'hffff_ffff;
		for (int i = 4; i < 8; i++) begin
			pool[i] = $urandom;
		end

		// random phases of 40: fill, drain or mixed; the first one fills
		bias = 0;
		for (int k = 0; k < RANDOM_REQS; k++) begin
			if (k != 0 && k % 40 == 0) begin
				bias = $urandom_range(0, 2);
			end
			enq_pct = (bias == 0) ? 75 : (bias == 1) ? 20 : 45;
			r = $urandom_range(0, 99);
			if (r < enq_pct) begin
				op = OP_ENQUEUE;
			end else if (r < 97) begin
				op = $urandom_range(0, 1) ? OP_REMOVE : OP_DEQUEUE;
			end else begin
				op = OP_UNUSED;
			end
			value = ($urandom_range(0, 99) < 75) ? pool[$urandom_range(0, 7)] : $urandom;
			push_req(op, value);
		end

		// reset once, at the start
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// everything presented, taken and answered
		while (pending_reqs.size() != 0 || req_valid || owed_rsps.size() != 0) begin
			@(posedge clk);
		end
		// catch any stray late response
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d removals, %0d empty or not found, %0d full rejects",
			n_checked, n_removed, n_miss, n_full);
		$display("deepest fill level reached: %0d of %0d entries", max_fill, QDEPTH);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
